// ===== src/srl_pkg.sv =====
`default_nettype none

package srl_pkg;

  // default sizing
  localparam int CAPACITY_DEF = 16;
  localparam int ID_BITS_DEF  = 8;
  localparam int KEY_BITS_DEF = 16;

  // request actions
  localparam logic [1:0] ACT_INSERT    = 2'd0;
  localparam logic [1:0] ACT_DEL_MATCH = 2'd1;
  localparam logic [1:0] ACT_DEL_POS   = 2'd2;
  localparam logic [1:0] ACT_FIND      = 2'd3;

  // result status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

endpackage

`default_nettype wire

// ===== src/srl_store.sv =====
`default_nettype none

// record store: one write port, one read port with registered read data
module srl_store #(
  parameter int DEPTH = srl_pkg::CAPACITY_DEF,
  parameter int WIDTH = 2 * srl_pkg::ID_BITS_DEF + srl_pkg::KEY_BITS_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, data registered
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== src/sorted_record_list.sv =====
`default_nettype none

// channel   direction  handshake          fields
// request   in         start & !busy      action, winner_id, loser_id, margin, position
// result    out        done (one cycle)   status, entry_count
//
// one request at a time; busy stays high until its result has been issued
// insert walks down from the tail, shifting one entry a cycle
// delete by match walks up through the store reading one entry a cycle, then shifts the tail
// back one entry a cycle (delete by position only shifts); the single read port sets this pace
// full store, empty store and bad position answer in the cycle after the request
// synchronous reset empties the list; the result cannot be held off by the receiver

module sorted_record_list #(
  parameter int CAPACITY = srl_pkg::CAPACITY_DEF,
  parameter int ID_BITS  = srl_pkg::ID_BITS_DEF,
  parameter int KEY_BITS = srl_pkg::KEY_BITS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic [1:0]          action,
  input  wire logic [ID_BITS-1:0]  winner_id,
  input  wire logic [ID_BITS-1:0]  loser_id,
  input  wire logic [KEY_BITS-1:0] margin,
  input  wire logic [4:0]          position,
  output logic                     done,
  output logic [1:0]               status,
  output logic [4:0]               entry_count
);

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = (CNT_W > 5) ? CNT_W : 5;
  localparam int REC_W = 2 * ID_BITS + KEY_BITS;

  // sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_INS   = 3'd1;
  localparam logic [2:0] S_PUT   = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_SHIFT = 3'd4;

  logic [2:0]       state, state_next;
  logic [IDX_W-1:0] cur, cur_next;
  logic [CNT_W-1:0] count, count_next;
  logic             done_next;
  logic [1:0]       status_next;
  logic [1:0]       req_action;
  logic [REC_W-1:0] req_rec;

  logic             wr_en, rd_en;
  logic [IDX_W-1:0] wr_addr, rd_addr;
  logic [REC_W-1:0] wr_data, rd_data;

  logic [REC_W-1:0] in_rec;
  logic             accept, full, cur_last, pos_ok, pos_inner, key_greater;

  assign busy        = (state != S_IDLE);
  assign accept      = start && !busy;
  assign entry_count = 5'(count);
  assign in_rec      = {winner_id, loser_id, margin};
  assign full        = (count == CNT_W'(CAPACITY));
  assign cur_last    = ((CNT_W'(cur) + CNT_W'(1)) == count);
  assign pos_ok      = (position != 5'd0) && (CMP_W'(position) <= CMP_W'(count));
  assign pos_inner   = (CMP_W'(position) < CMP_W'(count));
  assign key_greater = (rd_data[KEY_BITS-1:0] > req_rec[KEY_BITS-1:0]);

  srl_store #(
    .DEPTH (CAPACITY),
    .WIDTH (REC_W)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // sequencer: at most one store entry read and one written per cycle
  always_comb begin
    state_next  = state;
    cur_next    = cur;
    count_next  = count;
    done_next   = 1'b0;
    status_next = status;
    rd_en       = 1'b0;
    rd_addr     = cur + IDX_W'(1);
    wr_en       = 1'b0;
    wr_addr     = cur;
    wr_data     = req_rec;

    unique case (state)
      S_IDLE: begin
        if (start) begin
          unique case (action) inside
            srl_pkg::ACT_INSERT: begin
              if (full) begin
                done_next   = 1'b1;
                status_next = srl_pkg::ST_FULL;
              end else if (count == '0) begin
                wr_en       = 1'b1;
                wr_addr     = '0;
                wr_data     = in_rec;
                count_next  = count + CNT_W'(1);
                done_next   = 1'b1;
                status_next = srl_pkg::ST_OK;
              end else begin
                rd_en      = 1'b1;
                rd_addr    = IDX_W'(count - CNT_W'(1));
                cur_next   = IDX_W'(count - CNT_W'(1));
                state_next = S_INS;
              end
            end
            srl_pkg::ACT_DEL_MATCH, srl_pkg::ACT_FIND: begin
              if (count == '0) begin
                done_next   = 1'b1;
                status_next = srl_pkg::ST_MISS;
              end else begin
                rd_en      = 1'b1;
                rd_addr    = '0;
                cur_next   = '0;
                state_next = S_SCAN;
              end
            end
            default: begin
              if (!pos_ok) begin
                done_next   = 1'b1;
                status_next = srl_pkg::ST_MISS;
              end else if (pos_inner) begin
                rd_en      = 1'b1;
                rd_addr    = IDX_W'(position);
                cur_next   = IDX_W'(position);
                state_next = S_SHIFT;
              end else begin
                count_next  = count - CNT_W'(1);
                done_next   = 1'b1;
                status_next = srl_pkg::ST_OK;
              end
            end
          endcase
        end
      end

      // walk down from the tail, moving each smaller-or-equal entry up one
      S_INS: begin
        wr_en   = 1'b1;
        wr_addr = cur + IDX_W'(1);
        if (key_greater) begin
          count_next  = count + CNT_W'(1);
          done_next   = 1'b1;
          status_next = srl_pkg::ST_OK;
          state_next  = S_IDLE;
        end else begin
          wr_data = rd_data;
          if (cur == '0) begin
            state_next = S_PUT;
          end else begin
            rd_en    = 1'b1;
            rd_addr  = cur - IDX_W'(1);
            cur_next = cur - IDX_W'(1);
          end
        end
      end

      // new record lands at the head
      S_PUT: begin
        wr_en       = 1'b1;
        wr_addr     = '0;
        count_next  = count + CNT_W'(1);
        done_next   = 1'b1;
        status_next = srl_pkg::ST_OK;
        state_next  = S_IDLE;
      end

      // search for the first entry equal in all fields
      S_SCAN: begin
        if (rd_data == req_rec) begin
          if (req_action == srl_pkg::ACT_FIND) begin
            done_next   = 1'b1;
            status_next = srl_pkg::ST_OK;
            state_next  = S_IDLE;
          end else if (cur_last) begin
            count_next  = count - CNT_W'(1);
            done_next   = 1'b1;
            status_next = srl_pkg::ST_OK;
            state_next  = S_IDLE;
          end else begin
            rd_en      = 1'b1;
            cur_next   = cur + IDX_W'(1);
            state_next = S_SHIFT;
          end
        end else if (cur_last) begin
          done_next   = 1'b1;
          status_next = srl_pkg::ST_MISS;
          state_next  = S_IDLE;
        end else begin
          rd_en    = 1'b1;
          cur_next = cur + IDX_W'(1);
        end
      end

      // close the gap: each later entry moves down one
      S_SHIFT: begin
        wr_en   = 1'b1;
        wr_addr = cur - IDX_W'(1);
        wr_data = rd_data;
        if (cur_last) begin
          count_next  = count - CNT_W'(1);
          done_next   = 1'b1;
          status_next = srl_pkg::ST_OK;
          state_next  = S_IDLE;
        end else begin
          rd_en    = 1'b1;
          cur_next = cur + IDX_W'(1);
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      done  <= done_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    cur    <= cur_next;
    status <= status_next;
    if (accept) begin
      req_action <= action;
      req_rec    <= in_rec;
    end
  end

  // a result is only issued once the sequencer is back at rest
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result issued while busy");

  // the list never grows beyond its capacity
  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("entry count beyond capacity");

  // every accepted request either answers at once or keeps the block busy
  a_accept_prog: assert property (@(posedge clk) disable iff (rst)
    accept |=> (done || busy))
    else $error("request accepted with no progress");

  // a full status only comes from a full store
  a_full_stat: assert property (@(posedge clk) disable iff (rst)
    (done && status == srl_pkg::ST_FULL) |-> full)
    else $error("full status with room left");

endmodule

`default_nettype wire
